[rtl/ufk_pkg.sv]
// ----------------------------------------------------------------------------
// ufk_pkg
// Shared types and constants for the disjoint-set forest / spanning tree engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ufk_pkg;

	// Forest geometry
	localparam int MAX_NODES = 1024;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int COUNT_W   = NODE_W + 1;
	localparam int RANK_W    = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	// Payload widths
	localparam int WEIGHT_W = 32;
	localparam int COST_W   = 48;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(MAX_NODES);

	// Request kinds
	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_CONNECT = 2'd1,
		KIND_EDGE    = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [WEIGHT_W-1:0] edge_weight;
	} req_t;

	typedef struct packed {
		logic              joined;
		logic [COST_W-1:0] total_cost;
		logic              bad_index;
	} rsp_t;

	// One forest memory entry
	typedef struct packed {
		logic [NODE_W-1:0] parent;
		logic [RANK_W-1:0] rank;
	} entry_t;

endpackage

`default_nettype wire

[rtl/ufk_if.sv]
// ----------------------------------------------------------------------------
// ufk request / result channels
// Valid/ready channels carrying one request or one result per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufk_req_if;
	import ufk_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ufk_rsp_if;
	import ufk_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/ufk_engine.sv]
// ----------------------------------------------------------------------------
// ufk_engine
// Forest memory and its sequencer: root walks, path compression, union by
// rank, clearing sweep and cost accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module ufk_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire ufk_pkg::req_t             in_data,
	input  wire logic [ufk_pkg::COUNT_W-1:0] node_count,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output ufk_pkg::rsp_t                  res_data
);
	import ufk_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_FIND  = 7'b0000100,
		ST_COMP  = 7'b0001000,
		ST_UNION = 7'b0010000,
		ST_RANK  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);

	// Forest memory, one read and one write port
	entry_t mem [MAX_NODES];
	entry_t rd_q;

	logic              we;
	logic [NODE_W-1:0] waddr;
	logic [NODE_W-1:0] raddr;
	entry_t            wdata;

	state_t              state_q;
	logic [NODE_W-1:0]   clr_q;
	logic                clr_item_q;
	logic                side_q;
	logic [NODE_W-1:0]   cur_q;
	logic [NODE_W-1:0]   a_q;
	logic [NODE_W-1:0]   b_q;
	kind_t               kind_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [NODE_W-1:0]   ra_q;
	logic [NODE_W-1:0]   rb_q;
	logic [RANK_W-1:0]   rka_q;
	logic [RANK_W-1:0]   rkb_q;
	logic                joined_q;
	logic                bad_q;
	logic [COST_W-1:0]   total_q;

	logic [COUNT_W-1:0]  limit;
	logic                idx_bad;
	logic [NODE_W-1:0]   start_node;
	logic [NODE_W-1:0]   root_sel;
	logic                at_root;
	logic [COST_W:0]     sum;

	// Index check against the effective count
	assign limit   = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;
	assign idx_bad = ({1'b0, in_data.node_a} >= limit) || ({1'b0, in_data.node_b} >= limit);

	assign start_node = side_q ? b_q : a_q;
	assign root_sel   = side_q ? rb_q : ra_q;
	assign at_root    = (rd_q.parent == cur_q);

	// Saturating cost add
	assign sum = {1'b0, total_q} + (COST_W + 1)'(w_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_data  = '{joined: joined_q, total_cost: total_q, bad_index: bad_q};

	// Memory port control
	always_comb begin
		raddr = cur_q;
		we    = 1'b0;
		waddr = clr_q;
		wdata = '{parent: clr_q, rank: '0};
		case (state_q)
			ST_IDLE: begin
				raddr = in_data.node_a;
			end
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_FIND: begin
				raddr = at_root ? start_node : rd_q.parent;
			end
			ST_COMP: begin
				if (cur_q == root_sel) begin
					raddr = b_q;
				end else begin
					// point the node straight at its root, rank kept
					we    = 1'b1;
					waddr = cur_q;
					wdata = '{parent: root_sel, rank: rd_q.rank};
					raddr = rd_q.parent;
				end
			end
			ST_UNION: begin
				if (ra_q != rb_q) begin
					we = 1'b1;
					if (rka_q < rkb_q) begin
						waddr = ra_q;
						wdata = '{parent: rb_q, rank: rka_q};
					end else begin
						waddr = rb_q;
						wdata = '{parent: ra_q, rank: rkb_q};
					end
				end
			end
			ST_RANK: begin
				we    = 1'b1;
				waddr = ra_q;
				wdata = '{parent: ra_q, rank: (rka_q == RANK_MAX) ? rka_q : rka_q + 1'b1};
			end
			default: begin
				raddr = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					a_q      <= in_data.node_a;
					b_q      <= in_data.node_b;
					kind_q   <= in_data.kind;
					w_q      <= in_data.edge_weight;
					cur_q    <= in_data.node_a;
					joined_q <= 1'b0;
					bad_q    <= ((in_data.kind == KIND_CONNECT) || (in_data.kind == KIND_EDGE))
						&& idx_bad;
				end
			end
			ST_FIND: begin
				if (at_root) begin
					if (side_q) begin
						rb_q  <= cur_q;
						rkb_q <= rd_q.rank;
					end else begin
						ra_q  <= cur_q;
						rka_q <= rd_q.rank;
					end
					cur_q <= start_node;
				end else begin
					cur_q <= rd_q.parent;
				end
			end
			ST_COMP: begin
				if (cur_q == root_sel) begin
					cur_q <= b_q;
				end else begin
					cur_q <= rd_q.parent;
				end
			end
			ST_UNION: begin
				joined_q <= (ra_q != rb_q);
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// Sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			clr_item_q <= 1'b0;
			side_q     <= 1'b0;
			total_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						side_q <= 1'b0;
						case (in_data.kind)
							KIND_START: begin
								total_q    <= '0;
								clr_q      <= '0;
								clr_item_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							KIND_CONNECT, KIND_EDGE: begin
								state_q <= idx_bad ? ST_DONE : ST_FIND;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_NODE) begin
						state_q <= clr_item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_FIND: begin
					if (at_root) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (cur_q == root_sel) begin
						if (side_q) begin
							state_q <= ST_UNION;
						end else begin
							side_q  <= 1'b1;
							state_q <= ST_FIND;
						end
					end
				end
				ST_UNION: begin
					if (ra_q == rb_q) begin
						state_q <= ST_DONE;
					end else begin
						if (kind_q == KIND_EDGE) begin
							total_q <= sum[COST_W] ? '1 : sum[COST_W-1:0];
						end
						state_q <= (rka_q == rkb_q) ? ST_RANK : ST_DONE;
					end
				end
				ST_RANK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/union_find_kruskal_mst.sv]
// A connect or edge request walks each endpoint in turn to its root and then runs a
//   compression pass over that path; then comes the union step, and a rank step when
//   equal ranks merge. An ignored request goes straight to its result; a start sweeps
//   the forest memory. One request at a time, set by the single forest memory.
// Reset: a clearing pass runs first; no request is taken meanwhile,
//   configuration writes are taken as ever.
// ----------------------------------------------------------------------------
// union_find_kruskal_mst
// Spanning tree cost engine over a disjoint-set forest with an APB config port.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_kruskal_mst (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ufk_req_if.sink                             item,
	ufk_rsp_if.source                           result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ufk_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [ufk_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ufk_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import ufk_pkg::*;

	logic [COUNT_W-1:0] node_count_q;
	logic               reg_idx;
	logic               eng_res_valid;
	logic               eng_res_ready;
	rsp_t               eng_res;
	logic               out_valid_q;
	rsp_t               out_data_q;

	// Config register
	assign reg_idx = paddr[CFG_ADDR_W-1];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_NODE_COUNT) ? CFG_DATA_W'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (psel && penable && pwrite && (reg_idx == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	ufk_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_ready   (item.ready),
		.in_data    (item.data),
		.node_count (node_count_q),
		.res_valid  (eng_res_valid),
		.res_ready  (eng_res_ready),
		.res_data   (eng_res)
	);

	// Result register: frees the engine while a result waits
	assign eng_res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res_ready) begin
			out_valid_q <= eng_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_ready && eng_res_valid) begin
			out_data_q <= eng_res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

`default_nettype wire

[tb/sv/union_find_kruskal_mst_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_kruskal_mst_test
// Self-checking bench for the disjoint-set forest / spanning tree cost engine.
// A queue of requests feeds a clocked driver. On each accepted request a
// shadow forest (union by rank, path compression, saturating cost) predicts
// the result. A clocked monitor compares every result field by field.
// node_count is rewritten over the APB port between phases, read back each
// time, and both channels stall in random bursts.
// ----------------------------------------------------------------------------

module union_find_kruskal_mst_test;
	import ufk_pkg::*;

	localparam int ITEM_TARGET = 1850;
	localparam logic [CFG_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	ufk_req_if item_ch ();
	ufk_rsp_if result_ch ();

	union_find_kruskal_mst dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the forest, the cost and the count register
	logic [NODE_W-1:0]  shadow_parent [MAX_NODES];
	logic [RANK_W-1:0]  shadow_rank [MAX_NODES];
	logic [COST_W-1:0]  shadow_cost;
	logic [COUNT_W-1:0] shadow_count;

	req_t req_backlog[$];
	rsp_t awaited_results[$];

	int unsigned queued_cnt, accepted_cnt, useful_cnt;
	int unsigned mismatch_cnt, results_checked, merges_seen, flagged_seen;
	int unsigned starts_sent, settings_cnt;
	int unsigned src_gap, snk_gap, src_idle_pct, snk_idle_pct;
	rsp_t seen_rsp, want_rsp;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_cnt++;
	endtask

	function automatic void clear_shadow_forest();
		for (int i = 0; i < MAX_NODES; i++) begin
			shadow_parent[i] = NODE_W'(i);
			shadow_rank[i] = '0;
		end
	endfunction

	// node_count capped at the forest size
	function automatic int unsigned live_nodes();
		return (shadow_count < MAX_NODES) ? shadow_count : MAX_NODES;
	endfunction

	// Root walk, then point every node on the path straight at the root
	function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] node);
		logic [NODE_W-1:0] r, cur, nxt;
		r = node;
		while (shadow_parent[r] != r)
			r = shadow_parent[r];
		cur = node;
		while (cur != r) begin
			nxt = shadow_parent[cur];
			shadow_parent[cur] = r;
			cur = nxt;
		end
		return r;
	endfunction

	// Expected result of one request; updates the shadow state
	function automatic rsp_t forest_step(input req_t rq);
		rsp_t rs;
		int unsigned lim;
		logic [NODE_W-1:0] ra, rb;
		logic [COST_W:0] sum;
		rs = '0;
		lim = live_nodes();
		case (rq.kind)
			KIND_START: begin
				clear_shadow_forest();
				shadow_cost = '0;
			end
			KIND_CONNECT, KIND_EDGE: begin
				if (rq.node_a >= lim || rq.node_b >= lim) begin
					rs.bad_index = 1'b1;
				end else begin
					ra = find_root(rq.node_a);
					rb = find_root(rq.node_b);
					if (ra != rb) begin
						// lower rank goes under; on a tie node_a's root wins and grows
						if (shadow_rank[ra] < shadow_rank[rb]) begin
							shadow_parent[ra] = rb;
						end else if (shadow_rank[ra] > shadow_rank[rb]) begin
							shadow_parent[rb] = ra;
						end else begin
							shadow_parent[rb] = ra;
							if (shadow_rank[ra] != RANK_MAX)
								shadow_rank[ra] = shadow_rank[ra] + 1'b1;
						end
						rs.joined = 1'b1;
						if (rq.kind == KIND_EDGE) begin
							sum = {1'b0, shadow_cost} + rq.edge_weight;
							shadow_cost = sum[COST_W] ? '1 : sum[COST_W-1:0];
						end
					end
				end
			end
			default: ;
		endcase
		rs.total_cost = shadow_cost;
		return rs;
	endfunction

	// Request driver: holds a request until taken, idles in bursts
	always @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) begin
			awaited_results.insert(awaited_results.size(), forest_step(item_ch.data));
			accepted_cnt++;
		end
		if (!item_ch.valid || item_ch.ready) begin
			if (src_gap > 0) begin
				src_gap--;
				item_ch.valid <= 1'b0;
			end else if (req_backlog.size() == 0) begin
				item_ch.valid <= 1'b0;
			end else if ($urandom_range(0, 99) < src_idle_pct) begin
				src_gap = $urandom_range(0, 8);
				item_ch.valid <= 1'b0;
			end else begin
				item_ch.data <= req_backlog.pop_front();
				item_ch.valid <= 1'b1;
			end
		end
	end

	// Result monitor: compare against the oldest prediction, stall in bursts
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			seen_rsp = result_ch.data;
			if (awaited_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want_rsp = awaited_results.pop_front();
				results_checked++;
				merges_seen += want_rsp.joined;
				flagged_seen += want_rsp.bad_index;
				if (seen_rsp.joined !== want_rsp.joined)
					report_mismatch($sformatf("joined %b, want %b",
						seen_rsp.joined, want_rsp.joined));
				if (seen_rsp.total_cost !== want_rsp.total_cost)
					report_mismatch($sformatf("total_cost %h, want %h",
						seen_rsp.total_cost, want_rsp.total_cost));
				if (seen_rsp.bad_index !== want_rsp.bad_index)
					report_mismatch($sformatf("bad_index %b, want %b",
						seen_rsp.bad_index, want_rsp.bad_index));
			end
		end
		if (snk_gap > 0) begin
			snk_gap--;
			result_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < snk_idle_pct) begin
			snk_gap = $urandom_range(0, 8);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic queue_request(input kind_t k, input int unsigned a, input int unsigned b,
		input logic [WEIGHT_W-1:0] w);
		req_t rq;
		rq.kind = k;
		rq.node_a = a[NODE_W-1:0];
		rq.node_b = b[NODE_W-1:0];
		rq.edge_weight = w;
		if (k == KIND_START)
			starts_sent++;
		if (k == KIND_START || (k != KIND_UNUSED && rq.node_a < live_nodes() &&
			rq.node_b < live_nodes()))
			useful_cnt++;
		req_backlog.insert(req_backlog.size(), rq);
		queued_cnt++;
	endtask

	// Everything sent has been answered, then a short settling margin
	task automatic wait_drained();
		do @(negedge clk);
		while (accepted_cnt != queued_cnt || awaited_results.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	// One APB transfer: setup, then access; read data sampled mid access
	task automatic apb_access(input bit wr, input logic [CFG_DATA_W-1:0] wdata,
		output logic [CFG_DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= NODE_COUNT_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdata = prdata;
		end while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Read back, write, read back again
	task automatic set_node_count(input logic [COUNT_W-1:0] value);
		logic [CFG_DATA_W-1:0] rd;
		int step;
		for (step = 0; step < 3; step++) begin
			apb_access(step == 1, CFG_DATA_W'(value), rd);
			if (step != 1 && rd[COUNT_W-1:0] !== shadow_count)
				report_mismatch($sformatf("node_count reads %0d, want %0d",
					rd[COUNT_W-1:0], shadow_count));
			if (step == 1)
				shadow_count = value;
		end
		settings_cnt++;
	endtask

	// Stimulus
	initial begin
		int unsigned phase_no, span, span_cap, win_lo, win_hi, n, pick;
		logic [COUNT_W-1:0] cnt;
		logic [WEIGHT_W-1:0] wt;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		clear_shadow_forest();
		shadow_cost = '0;
		shadow_count = NODE_COUNT_RST;
		src_idle_pct = 20;
		snk_idle_pct = 20;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: full forest, zero and maximum weights, same-tree edges,
		// equal-rank and lower-rank merges, unused kind
		set_node_count(11'd1024);
		queue_request(KIND_START, 1023, 1023, WEIGHT_MAX);
		queue_request(KIND_CONNECT, 0, 1023, 0);
		queue_request(KIND_EDGE, 0, 1023, 5);
		queue_request(KIND_EDGE, 1, 2, 0);
		queue_request(KIND_EDGE, 3, 4, WEIGHT_MAX);
		queue_request(KIND_EDGE, 1, 1, 7);
		queue_request(KIND_CONNECT, 5, 6, 0);
		queue_request(KIND_CONNECT, 7, 8, 0);
		queue_request(KIND_CONNECT, 6, 8, 0);
		queue_request(KIND_CONNECT, 9, 5, 0);
		queue_request(KIND_EDGE, 9, 7, WEIGHT_MAX);
		queue_request(KIND_UNUSED, 1023, 0, WEIGHT_MAX);
		wait_drained();

		// Small count: out-of-range indices on either side
		set_node_count(11'd3);
		queue_request(KIND_CONNECT, 2, 3, 0);
		queue_request(KIND_EDGE, 1023, 0, 100);
		queue_request(KIND_CONNECT, 0, 2, 0);
		queue_request(KIND_EDGE, 1, 2, 32'h100);
		queue_request(KIND_UNUSED, 1023, 1023, 0);
		wait_drained();

		// Zero count: every index is bad, a start still clears
		set_node_count(11'd0);
		queue_request(KIND_CONNECT, 0, 0, 0);
		queue_request(KIND_EDGE, 0, 0, WEIGHT_MAX);
		queue_request(KIND_START, 1023, 1023, 0);
		wait_drained();

		// Count beyond the forest size behaves as the forest size
		set_node_count(11'd2047);
		queue_request(KIND_EDGE, 1023, 1022, 32'h8000_0000);
		queue_request(KIND_EDGE, 1022, 0, 32'h8000_0000);
		wait_drained();

		// Random phases: a count setting, then a few forests of sorted edges
		phase_no = 0;
		while (queued_cnt < ITEM_TARGET) begin
			case (phase_no % 9)
				0: cnt = 11'd1;
				1: cnt = 11'd2047;
				2: cnt = 11'd2;
				3: cnt = 11'd1023;
				4: cnt = 11'd0;
				5: cnt = 11'd1024;
				6: cnt = COUNT_W'($urandom_range(3, 1023));
				7: cnt = 11'd64;
				default: cnt = COUNT_W'($urandom_range(1025, 2047));
			endcase
			if (queued_cnt + 200 > ITEM_TARGET) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else begin
				src_idle_pct = $urandom_range(0, 2) * 20;
				snk_idle_pct = $urandom_range(0, 2) * 20;
			end
			set_node_count(cnt);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 9) != 0)
					queue_request(KIND_START, $urandom, $urandom, $urandom);
				// mostly a narrow window of nodes, so trees grow deep
				if (live_nodes() == 0) begin
					win_lo = 0;
					win_hi = MAX_NODES - 1;
					n = 8;
				end else begin
					span_cap = ($urandom_range(0, 3) == 0) ? live_nodes() : $urandom_range(1, 48);
					span = $urandom_range(1, (span_cap < live_nodes()) ? span_cap : live_nodes());
					win_lo = $urandom_range(0, live_nodes() - span);
					win_hi = win_lo + span - 1;
					n = $urandom_range(15, 70);
				end
				wt = $urandom >> $urandom_range(0, 31);
				repeat (n) begin
					pick = $urandom_range(0, 99);
					if (pick < 60) begin
						n = $urandom_range(0, 1 << $urandom_range(0, 24));
						wt = (wt > WEIGHT_MAX - n) ? WEIGHT_MAX : wt + n;
						queue_request(KIND_EDGE, $urandom_range(win_lo, win_hi),
							$urandom_range(win_lo, win_hi), wt);
					end else if (pick < 80) begin
						queue_request(KIND_CONNECT, $urandom_range(win_lo, win_hi),
							$urandom_range(win_lo, win_hi), $urandom);
					end else if (pick < 90) begin
						queue_request(($urandom_range(0, 1) == 0) ? KIND_CONNECT : KIND_EDGE,
							$urandom_range(0, MAX_NODES - 1), $urandom_range(0, MAX_NODES - 1),
							$urandom);
					end else if (pick < 95) begin
						queue_request(KIND_UNUSED, $urandom, $urandom, $urandom);
					end else begin
						// out of weight order
						queue_request(KIND_EDGE, $urandom_range(win_lo, win_hi),
							$urandom_range(win_lo, win_hi), $urandom);
					end
				end
			end
			wait_drained();
			phase_no++;
		end

		repeat (64) @(posedge clk);
		$display("Checked %0d results over %0d node-count settings and %0d fresh forests",
			results_checked, settings_cnt, starts_sent);
		$display("Seen %0d tree merges, %0d in-range requests and %0d out-of-range ones",
			merges_seen, useful_cnt, flagged_seen);
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Run stalled: %0d of %0d requests taken, %0d results awaited",
			accepted_cnt, queued_cnt, awaited_results.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
